/* hdl/kli_pkg.sv */
package kli_pkg;

    localparam int KLI_MAX_KEYFRAMES = 16;
    localparam int KLI_NUM_CHANNELS  = 16;

    localparam logic [15:0] KLI_STEPS_RESET  = 16'd100;
    localparam logic [4:0]  KLI_FRAMES_RESET = 5'd0;

    // Request codes carried in req_type.
    localparam logic [1:0] REQ_WRITE = 2'd0;
    localparam logic [1:0] REQ_PLAY  = 2'd1;
    localparam logic [1:0] REQ_TICK  = 2'd2;

    // Configuration register indexes.
    localparam logic CFG_STEPS  = 1'b0;
    localparam logic CFG_FRAMES = 1'b1;

    typedef struct packed {
        logic [1:0]         req_type;
        logic [3:0]         frame_index;
        logic [3:0]         channel_index;
        logic signed [23:0] key_value;
    } kli_in_t;

    typedef struct packed {
        logic [3:0]         channel;
        logic signed [23:0] pose_value;
        logic               playing;
        logic [3:0]         segment;
        logic               last;
    } kli_out_t;

endpackage

/* hdl/kli_ram.sv */
module kli_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

/* hdl/kli_div.sv */
module kli_div
    import kli_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    input  logic signed [24:0] diff,
    input  logic [15:0]        steps,
    output logic               done,
    output logic signed [31:0] result
);

    // Restoring division of |diff| * 256 by steps, one quotient bit per cycle.
    logic        busy_reg;
    logic [4:0]  cnt_reg;
    logic [16:0] rem_reg;
    logic [31:0] quo_reg;
    logic [15:0] divisor_reg;
    logic        neg_reg;
    logic        zero_reg;
    logic        done_reg;

    logic [16:0] trial;
    logic        fits;
    logic [24:0] mag;

    assign trial = {rem_reg[15:0], quo_reg[31]};
    assign fits  = trial >= {1'b0, divisor_reg};
    assign mag   = diff[24] ? 25'(-diff) : 25'(diff);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg    <= 1'b0;
            cnt_reg     <= '0;
            rem_reg     <= '0;
            quo_reg     <= '0;
            divisor_reg <= '0;
            neg_reg     <= 1'b0;
            zero_reg    <= 1'b0;
            done_reg    <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg    <= 1'b1;
                cnt_reg     <= '0;
                rem_reg     <= '0;
                quo_reg     <= {mag[23:0], 8'h00};
                divisor_reg <= steps;
                neg_reg     <= diff[24];
                zero_reg    <= (steps == 16'd0);
            end
            else if (busy_reg)
            begin
                rem_reg <= fits ? (trial - {1'b0, divisor_reg}) : trial;
                quo_reg <= {quo_reg[30:0], fits};
                cnt_reg <= cnt_reg + 5'd1;
                if (cnt_reg == 5'd31)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    assign done = done_reg;

    always_comb
    begin
        if (zero_reg)
        begin
            result = '0;
        end
        else if (neg_reg)
        begin
            result = (quo_reg > 32'h8000_0000) ? 32'sh8000_0000 : signed'(-quo_reg);
        end
        else
        begin
            result = quo_reg[31] ? 32'sh7FFF_FFFF : signed'(quo_reg);
        end
    end

endmodule

/* hdl/keyframe_linear_interpolator.sv */
// Keyframe sequencer with linear interpolation between consecutive keyframes.
// Input channel (in_valid/in_ready/in_item) takes keyframe writes, play/pause
// presses and animation ticks. The output channel (out_valid/out_ready/out_item)
// returns one transaction per channel, channel 0 first, with last set on the
// final channel, for every play and tick request. Writes return nothing.
// The block takes one request at a time; in_ready is high only between requests.
// A plain tick makes one add pass and then one report pass over the channels;
// a pause or any tick that does not add or reload makes only the report pass.
// A play start or a segment change recomputes every increment with a
// bit-serial divider, channel by channel: two table reads, divider start,
// the 32 quotient bits, then done is seen and the increment written back;
// the report pass follows the last channel.
// The configuration port (cfg_write/cfg_index/cfg_data) is written when
// cfg_write is high and must only be used while the block is idle.
// Reset clears the pose, increments, segment and step counters and stops
// playback; the keyframe table is not cleared and must be written before use.
// When the receiver stalls, the report pass waits on the output register.
module keyframe_linear_interpolator
    import kli_pkg::*;
#(
    parameter int MAX_KEYFRAMES = KLI_MAX_KEYFRAMES,
    parameter int NUM_CHANNELS  = KLI_NUM_CHANNELS
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  kli_in_t     in_item,
    output logic        out_valid,
    input  logic        out_ready,
    output kli_out_t    out_item,
    input  logic        cfg_write,
    input  logic        cfg_index,
    input  logic [15:0] cfg_data
);

    localparam int CW    = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
    localparam int SW    = $clog2(MAX_KEYFRAMES);
    localparam int DEPTH = MAX_KEYFRAMES * NUM_CHANNELS;
    localparam int AW    = $clog2(DEPTH);

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_RD0    = 3'd1;
    localparam logic [2:0] S_RD1    = 3'd2;
    localparam logic [2:0] S_DSTART = 3'd3;
    localparam logic [2:0] S_DIV    = 3'd4;
    localparam logic [2:0] S_ADD    = 3'd5;
    localparam logic [2:0] S_REP    = 3'd6;

    logic [2:0]         state_reg;
    logic [15:0]        steps_reg;
    logic [4:0]         frames_reg;
    logic [SW-1:0]      seg_reg;
    logic [15:0]        step_reg;
    logic               play_reg;
    logic               load_reg;
    logic [CW-1:0]      ch_reg;
    logic signed [23:0] cur_reg;
    logic signed [31:0] pose_reg [NUM_CHANNELS];
    logic signed [31:0] inc_reg [NUM_CHANNELS];
    logic               out_valid_reg;
    kli_out_t           out_reg;

    logic               accept;
    logic [7:0]         usable;
    logic               ch_last;
    logic               ram_we;
    logic [AW-1:0]      ram_waddr;
    logic [AW-1:0]      ram_raddr;
    logic [SW-1:0]      rd_frame;
    logic [23:0]        rd_data;
    logic signed [24:0] diff;
    logic               div_done;
    logic signed [31:0] div_result;
    logic signed [32:0] sum;
    logic signed [31:0] sum_sat;

    assign in_ready = (state_reg == S_IDLE);
    assign accept   = in_valid && in_ready;
    assign usable   = (8'(frames_reg) > 8'(MAX_KEYFRAMES)) ? 8'(MAX_KEYFRAMES)
                                                           : 8'(frames_reg);
    assign ch_last  = (ch_reg == CW'(NUM_CHANNELS - 1));

    // Out-of-range writes are dropped.
    assign ram_we = accept && (in_item.req_type == REQ_WRITE)
                    && (8'(in_item.frame_index) < 8'(MAX_KEYFRAMES))
                    && (8'(in_item.channel_index) < 8'(NUM_CHANNELS));
    assign ram_waddr = AW'(AW'(in_item.frame_index) * AW'(NUM_CHANNELS)
                           + AW'(in_item.channel_index));
    assign rd_frame  = (state_reg == S_RD0) ? seg_reg : SW'(seg_reg + 1'b1);
    assign ram_raddr = AW'(AW'(rd_frame) * AW'(NUM_CHANNELS) + AW'(ch_reg));

    kli_ram #(
        .WIDTH(24),
        .DEPTH(DEPTH)
    ) u_table (
        .clk  (clk),
        .we   (ram_we),
        .waddr(ram_waddr),
        .wdata(in_item.key_value),
        .raddr(ram_raddr),
        .rdata(rd_data)
    );

    assign diff = 25'(signed'(rd_data)) - 25'(cur_reg);

    kli_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (state_reg == S_DSTART),
        .diff  (diff),
        .steps (steps_reg),
        .done  (div_done),
        .result(div_result)
    );

    assign sum = 33'(pose_reg[ch_reg]) + 33'(inc_reg[ch_reg]);
    always_comb
    begin
        if (sum[32] != sum[31])
        begin
            sum_sat = sum[32] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
        end
        else
        begin
            sum_sat = sum[31:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            steps_reg     <= KLI_STEPS_RESET;
            frames_reg    <= KLI_FRAMES_RESET;
            seg_reg       <= '0;
            step_reg      <= '0;
            play_reg      <= 1'b0;
            load_reg      <= 1'b0;
            ch_reg        <= '0;
            cur_reg       <= '0;
            out_valid_reg <= 1'b0;
            out_reg       <= '0;
            for (int i = 0; i < NUM_CHANNELS; i++)
            begin
                pose_reg[i] <= '0;
                inc_reg[i]  <= '0;
            end
        end
        else
        begin
            if (cfg_write)
            begin
                unique case (cfg_index)
                    CFG_STEPS:  steps_reg  <= cfg_data;
                    CFG_FRAMES: frames_reg <= cfg_data[4:0];
                    default:    ;
                endcase
            end

            if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end

            unique case (state_reg)
                S_IDLE:
                begin
                    if (accept)
                    begin
                        ch_reg <= '0;
                        case (in_item.req_type)
                            REQ_PLAY:
                            begin
                                if (!play_reg && usable > 8'd1)
                                begin
                                    play_reg  <= 1'b1;
                                    seg_reg   <= '0;
                                    step_reg  <= '0;
                                    load_reg  <= 1'b1;
                                    state_reg <= S_RD0;
                                end
                                else
                                begin
                                    play_reg  <= 1'b0;
                                    state_reg <= S_REP;
                                end
                            end
                            REQ_TICK:
                            begin
                                if (!play_reg)
                                begin
                                    state_reg <= S_REP;
                                end
                                else if (step_reg >= steps_reg)
                                begin
                                    // Segment end: advance, or stop after the last one.
                                    if (8'(seg_reg) + 8'd3 > usable)
                                    begin
                                        seg_reg   <= '0;
                                        play_reg  <= 1'b0;
                                        state_reg <= S_REP;
                                    end
                                    else
                                    begin
                                        seg_reg   <= SW'(seg_reg + 1'b1);
                                        step_reg  <= '0;
                                        load_reg  <= 1'b0;
                                        state_reg <= S_RD0;
                                    end
                                end
                                else
                                begin
                                    step_reg  <= step_reg + 16'd1;
                                    state_reg <= S_ADD;
                                end
                            end
                            default: ;
                        endcase
                    end
                end
                S_RD0:
                begin
                    state_reg <= S_RD1;
                end
                S_RD1:
                begin
                    cur_reg <= signed'(rd_data);
                    if (load_reg)
                    begin
                        pose_reg[ch_reg] <= {rd_data, 8'h00};
                    end
                    state_reg <= S_DSTART;
                end
                S_DSTART:
                begin
                    state_reg <= S_DIV;
                end
                S_DIV:
                begin
                    if (div_done)
                    begin
                        inc_reg[ch_reg] <= div_result;
                        if (ch_last)
                        begin
                            ch_reg    <= '0;
                            state_reg <= S_REP;
                        end
                        else
                        begin
                            ch_reg    <= ch_reg + 1'b1;
                            state_reg <= S_RD0;
                        end
                    end
                end
                S_ADD:
                begin
                    pose_reg[ch_reg] <= sum_sat;
                    if (ch_last)
                    begin
                        ch_reg    <= '0;
                        state_reg <= S_REP;
                    end
                    else
                    begin
                        ch_reg <= ch_reg + 1'b1;
                    end
                end
                S_REP:
                begin
                    if (!out_valid_reg || out_ready)
                    begin
                        out_valid_reg      <= 1'b1;
                        out_reg.channel    <= 4'(ch_reg);
                        out_reg.pose_value <= pose_reg[ch_reg][31:8];
                        out_reg.playing    <= play_reg;
                        out_reg.segment    <= 4'(seg_reg);
                        out_reg.last       <= ch_last;
                        if (ch_last)
                        begin
                            ch_reg    <= '0;
                            state_reg <= S_IDLE;
                        end
                        else
                        begin
                            ch_reg <= ch_reg + 1'b1;
                        end
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign out_valid = out_valid_reg;
    assign out_item  = out_reg;

`ifndef SYNTH
    a_write_idle: assert property (@(posedge clk) disable iff (!rst_n)
        ram_we |-> state_reg == S_IDLE)
        else $error("table write outside idle");

    a_div_done_in_div: assert property (@(posedge clk) disable iff (!rst_n)
        div_done |-> state_reg == S_DIV)
        else $error("divider finished outside the divide state");

    a_play_start: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(play_reg) |-> seg_reg == '0 && step_reg == 16'd0)
        else $error("playback started away from segment zero");

    a_report_gap: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_REP && out_valid_reg && !out_ready) |=> state_reg == S_REP)
        else $error("report pass left while output stalled");
`endif

endmodule

/* dv/tb_top.sv */
`timescale 1ns / 1ps

module tb_top;
    import kli_pkg::*;

    localparam int NCH         = KLI_NUM_CHANNELS;
    localparam int NFR         = KLI_MAX_KEYFRAMES;
    localparam int CYCLE_LIMIT = 3000000;
    localparam int LONG_HOLD   = 2500;
    // Frames written before any playback; no test reads a frame beyond them.
    localparam int FILL_FRAMES = 4;

    localparam logic [1:0] REQ_UNKNOWN = 2'd3;

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_ready;
    kli_in_t     in_item;
    logic        out_valid;
    logic        out_ready;
    kli_out_t    out_item;
    logic        cfg_write;
    logic        cfg_index;
    logic [15:0] cfg_data;

    keyframe_linear_interpolator u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_item   (in_item),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_item  (out_item),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // Shadow copy of the sequencer state.
    logic signed [23:0] key_tab [NFR][NCH];
    logic signed [31:0] pose_acc [NCH];
    logic signed [31:0] pose_inc [NCH];
    logic [3:0]         seg_idx;
    logic [15:0]        step_cnt;
    logic               is_playing;
    logic [15:0]        steps_cfg;
    logic [4:0]         frames_cfg;

    kli_in_t  pending_q[$];
    kli_out_t expected_pose_q[$];

    int errors;
    int n_writes, n_plays, n_ticks, n_checked, n_seg_ends;
    int cycles;
    int burst_left, idle_left;
    int rx_mode, rx_left, hold_left;
    bit hold_req, hold_done;

    initial clk = 1'b0;
    always #5 clk = ~clk;

    function automatic logic signed [31:0] sat32(longint v);
        if (v > 64'sd2147483647)
            return 32'sh7fffffff;
        if (v < -64'sd2147483648)
            return 32'sh80000000;
        return v[31:0];
    endfunction

    function automatic int usable_frames();
        return (frames_cfg > NFR) ? NFR : int'(frames_cfg);
    endfunction

    task automatic load_increments(int seg);
        longint diff;
        for (int c = 0; c < NCH; c++)
        begin
            diff = longint'(key_tab[seg + 1][c]) - longint'(key_tab[seg][c]);
            if (steps_cfg == 0)
                pose_inc[c] = '0;
            else
                pose_inc[c] = sat32((diff * 256) / longint'(steps_cfg));
        end
    endtask

    task automatic queue_pose_report();
        kli_out_t r;
        for (int c = 0; c < NCH; c++)
        begin
            r.channel    = c[3:0];
            r.pose_value = pose_acc[c][31:8];
            r.playing    = is_playing;
            r.segment    = seg_idx;
            r.last       = (c == NCH - 1);
            expected_pose_q.push_back(r);
        end
    endtask

    task automatic advance_sequencer(kli_in_t it);
        case (it.req_type)
            REQ_WRITE:
            begin
                key_tab[it.frame_index][it.channel_index] = it.key_value;
                n_writes++;
            end
            REQ_PLAY:
            begin
                if (!is_playing && usable_frames() > 1)
                begin
                    for (int c = 0; c < NCH; c++)
                        pose_acc[c] = {key_tab[0][c], 8'd0};
                    load_increments(0);
                    is_playing = 1'b1;
                    seg_idx    = '0;
                    step_cnt   = '0;
                end
                else
                    is_playing = 1'b0;
                n_plays++;
                queue_pose_report();
            end
            REQ_TICK:
            begin
                if (is_playing)
                begin
                    if (step_cnt >= steps_cfg)
                    begin
                        n_seg_ends++;
                        seg_idx = seg_idx + 1;
                        if (int'(seg_idx) + 2 > usable_frames())
                        begin
                            seg_idx    = '0;
                            is_playing = 1'b0;
                        end
                        else
                        begin
                            step_cnt = '0;
                            load_increments(seg_idx);
                        end
                    end
                    else
                    begin
                        for (int c = 0; c < NCH; c++)
                            pose_acc[c] = sat32(longint'(pose_acc[c]) + longint'(pose_inc[c]));
                        step_cnt = step_cnt + 1;
                    end
                end
                n_ticks++;
                queue_pose_report();
            end
            default: ;
        endcase
    endtask

    // Driver: bursts of back-to-back items separated by random gaps.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid   <= 1'b0;
            in_item    <= '0;
            burst_left <= 0;
            idle_left  <= 0;
        end
        else if (!in_valid || in_ready)
        begin
            if (idle_left != 0)
            begin
                idle_left <= idle_left - 1;
                in_valid  <= 1'b0;
            end
            else if (pending_q.size() != 0)
            begin
                in_item  <= pending_q.pop_front();
                in_valid <= 1'b1;
                if (burst_left <= 1)
                begin
                    burst_left <= $urandom_range(1, 12);
                    idle_left  <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 20);
                end
                else
                    burst_left <= burst_left - 1;
            end
            else
                in_valid <= 1'b0;
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && in_valid && in_ready)
            advance_sequencer(in_item);
    end

    // Receiver: switches between always ready, random stalls and a periodic
    // pattern, plus one long hold-off on request.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_ready <= 1'b0;
            rx_mode   <= 0;
            rx_left   <= 0;
            hold_left <= 0;
            hold_done <= 1'b0;
        end
        else if (hold_left != 0)
        begin
            hold_left <= hold_left - 1;
            out_ready <= 1'b0;
        end
        else if (hold_req && !hold_done)
        begin
            hold_done <= 1'b1;
            hold_left <= LONG_HOLD;
            out_ready <= 1'b0;
        end
        else
        begin
            if (rx_left == 0)
            begin
                rx_mode <= $urandom_range(0, 2);
                rx_left <= $urandom_range(20, 200);
            end
            else
                rx_left <= rx_left - 1;
            case (rx_mode)
                0:       out_ready <= 1'b1;
                1:       out_ready <= ($urandom_range(0, 9) < 6);
                default: out_ready <= (rx_left % 5 != 0);
            endcase
        end
    end

    always @(posedge clk)
    begin
        kli_out_t want;
        if (rst_n && out_valid && out_ready)
        begin
            if (expected_pose_q.size() == 0)
            begin
                $display("%0t: unexpected transaction ch=%0d pose=%0d playing=%0b seg=%0d last=%0b",
                         $time, out_item.channel, out_item.pose_value, out_item.playing,
                         out_item.segment, out_item.last);
                errors++;
            end
            else
            begin
                want = expected_pose_q.pop_front();
                if (out_item.channel !== want.channel || out_item.pose_value !== want.pose_value
                    || out_item.playing !== want.playing || out_item.segment !== want.segment
                    || out_item.last !== want.last)
                begin
                    $display("%0t: mismatch expected ch=%0d pose=%0d playing=%0b seg=%0d last=%0b",
                             $time, want.channel, want.pose_value, want.playing,
                             want.segment, want.last);
                    $display("%0t:          actual   ch=%0d pose=%0d playing=%0b seg=%0d last=%0b",
                             $time, out_item.channel, out_item.pose_value, out_item.playing,
                             out_item.segment, out_item.last);
                    errors++;
                end
                n_checked++;
            end
        end
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("%0t: timeout with %0d transactions outstanding", $time,
                     expected_pose_q.size());
            $display("** keyframe_linear_interpolator: FAILED **");
            $finish;
        end
    end

    function automatic kli_in_t mk(logic [1:0] req, int f = 0, int ch = 0, int v = 0);
        kli_in_t it;
        it.req_type      = req;
        it.frame_index   = f[3:0];
        it.channel_index = ch[3:0];
        it.key_value     = v[23:0];
        return it;
    endfunction

    function automatic kli_in_t random_item();
        int r;
        r = $urandom_range(0, 99);
        if (r < 62)
            return mk(REQ_TICK, $urandom, $urandom, $urandom);
        if (r < 78)
            return mk(REQ_PLAY, $urandom, $urandom, $urandom);
        if (r < 95)
            return mk(REQ_WRITE, $urandom_range(0, NFR - 1), $urandom_range(0, NCH - 1),
                      $urandom);
        return mk(REQ_UNKNOWN, $urandom, $urandom, $urandom);
    endfunction

    task automatic drain();
        while (pending_q.size() != 0 || in_valid || expected_pose_q.size() != 0)
            @(posedge clk);
        // A trailing write produces nothing, so let it finish before touching registers.
        repeat (40) @(posedge clk);
    endtask

    task automatic write_reg(logic idx, int val);
        @(posedge clk);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val[15:0];
        @(posedge clk);
        cfg_write <= 1'b0;
        if (idx == CFG_STEPS)
            steps_cfg = val[15:0];
        else
            frames_cfg = val[4:0];
    endtask

    task automatic set_regs(int steps, int frames);
        write_reg(CFG_STEPS, steps);
        write_reg(CFG_FRAMES, frames);
    endtask

    initial
    begin
        int steps_set [5] = '{1, 65535, 3, 2, 0};
        int frames_set[5] = '{4, 4, 3, 1, 4};
        int v;

        errors = 0; cycles = 0;
        n_writes = 0; n_plays = 0; n_ticks = 0; n_checked = 0; n_seg_ends = 0;
        hold_req   = 1'b0;
        cfg_write  = 1'b0;
        cfg_index  = CFG_STEPS;
        cfg_data   = '0;
        steps_cfg  = KLI_STEPS_RESET;
        frames_cfg = KLI_FRAMES_RESET;
        seg_idx    = '0;
        step_cnt   = '0;
        is_playing = 1'b0;
        for (int c = 0; c < NCH; c++)
        begin
            pose_acc[c] = '0;
            pose_inc[c] = '0;
        end
        rst_n = 1'b0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;

        // Reset settings: too few frames, so play stays stopped; a stopped tick
        // still reports; an unknown request is dropped.
        pending_q.push_back(mk(REQ_PLAY));
        pending_q.push_back(mk(REQ_TICK));
        pending_q.push_back(mk(REQ_UNKNOWN, 15, 15, -1));
        drain();

        // Fill the leading frames; playback below never reaches past them.
        // Frames 0 and 1 take opposite extremes to push increments into saturation.
        for (int f = 0; f < FILL_FRAMES; f++)
            for (int c = 0; c < NCH; c++)
            begin
                if (f < 2)
                    v = ((f + c) % 2 == 0) ? 8388607 : -8388608;
                else
                    v = $urandom;
                pending_q.push_back(mk(REQ_WRITE, f, c, v));
            end
        drain();

        // Two frames, one step: start, add, segment end stops, play, pause.
        set_regs(1, 2);
        pending_q.push_back(mk(REQ_PLAY));
        pending_q.push_back(mk(REQ_TICK));
        pending_q.push_back(mk(REQ_TICK));
        pending_q.push_back(mk(REQ_PLAY));
        pending_q.push_back(mk(REQ_PLAY));
        drain();

        // Zero steps with a frame count past the table size.
        set_regs(0, 31);
        pending_q.push_back(mk(REQ_PLAY));
        repeat (2) pending_q.push_back(mk(REQ_TICK));
        pending_q.push_back(mk(REQ_PLAY));
        drain();

        // Frame count lowered while playing.
        set_regs(2, 16);
        pending_q.push_back(mk(REQ_PLAY));
        pending_q.push_back(mk(REQ_TICK));
        drain();
        set_regs(2, 3);
        repeat (7) pending_q.push_back(mk(REQ_TICK));
        drain();

        // Random phases: each opens with a play and then mostly ticks.
        for (int p = 0; p < 5; p++)
        begin
            set_regs(steps_set[p], frames_set[p]);
            if (p == 2)
                hold_req = 1'b1;
            pending_q.push_back(mk(REQ_PLAY));
            for (int i = 0; i < 6; i++)
                pending_q.push_back(random_item());
            drain();
        end

        $display("Covered %0d writes, %0d plays and %0d ticks; %0d segment ends.",
                 n_writes, n_plays, n_ticks, n_seg_ends);
        $display("Checked %0d pose transactions against the shadow model.", n_checked);
        if (errors == 0)
            $display("** keyframe_linear_interpolator: PASSED **");
        else
            $display("** keyframe_linear_interpolator: FAILED **");
        $finish;
    end

endmodule
